// ===== hdl/lkv_pkg.sv =====
// shared types and constants for the lru key-value cache
package lkv_pkg;

  localparam int KEY_W           = 32;
  localparam int VAL_W           = 32;
  localparam int CAP_W           = 5;
  localparam int MAX_ENTRIES_DEF = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_STORE  = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] value;
  } result_t;

endpackage

// ===== hdl/lkv_in_if.sv =====
// request channel interface of the lru key-value cache
interface lkv_in_if;
  import lkv_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [KEY_W-1:0] lookup_key;
  logic signed [VAL_W-1:0] store_value;

  modport source (output valid, kind, lookup_key, store_value, input ready);
  modport sink   (input valid, kind, lookup_key, store_value, output ready);
endinterface

// ===== hdl/lkv_out_if.sv =====
// result channel interface of the lru key-value cache
interface lkv_out_if;
  import lkv_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    found;
  logic signed [VAL_W-1:0] read_value;

  modport source (output valid, found, read_value, input ready);
  modport sink   (input valid, found, read_value, output ready);
endinterface

// ===== hdl/lkv_cfg_if.sv =====
// capacity write channel interface of the lru key-value cache
interface lkv_cfg_if;
  import lkv_pkg::*;

  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity_in_use;

  modport source (output valid, capacity_in_use, input ready);
  modport sink   (input valid, capacity_in_use, output ready);
endinterface

// ===== hdl/lru_key_value_cache.sv =====
// lru key-value cache: a lookup passes the input register, then the result register, whose
// output is held until the result handshake; a store gives no result
// throughput one transaction per cycle unless a lookup waits on a full result register;
// the compare and rank update over all entries are combinational, between the two registers
// reset clears valid marks, recency ranks and pipeline state and sets capacity to 16
// no clearing pass: the cache takes transactions as soon as reset is released
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lkv_in_if.sink    in_chan,
  lkv_out_if.source out_chan,
  lkv_cfg_if.sink   cfg_chan
);
  import lkv_pkg::*;

  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic             s1_valid, adv, res_valid, out_free;
  item_t            s1_item;
  result_t          res;

  assign cfg_chan.ready = 1'b1;

  always_comb begin
    cap_nxt = cap_r;
    if (cfg_chan.valid && cfg_chan.ready) begin
      cap_nxt = cfg_chan.capacity_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  lkv_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  lkv_core #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .capacity  (cap_r),
    .out_free  (out_free),
    .adv       (adv),
    .res_valid (res_valid),
    .res       (res)
  );

  lkv_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_chan  (out_chan)
  );
endmodule

// ===== hdl/lkv_in_reg.sv =====
// input register holding one request transaction
module lkv_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  lkv_in_if.sink         in_chan,
  input  logic           adv,
  output logic           s1_valid,
  output lkv_pkg::item_t s1_item
);
  import lkv_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  accept;

  assign in_chan.ready = !valid_r || adv;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (accept) begin
      valid_nxt      = 1'b1;
      item_nxt.kind  = in_chan.kind;
      item_nxt.key   = in_chan.lookup_key;
      item_nxt.value = in_chan.store_value;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;
endmodule

// ===== hdl/lkv_core.sv =====
// entry store with parallel key compare and recency rank update
module lkv_core #(
  parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    s1_valid,
  input  lkv_pkg::item_t          s1_item,
  input  logic [lkv_pkg::CAP_W-1:0] capacity,
  input  logic                    out_free,
  output logic                    adv,
  output logic                    res_valid,
  output lkv_pkg::result_t        res
);
  import lkv_pkg::*;

  localparam int RW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CMPW = (RW + 1 > CAP_W) ? RW + 1 : CAP_W;

  logic signed [KEY_W-1:0] key_r   [MAX_ENTRIES];
  logic signed [VAL_W-1:0] val_r   [MAX_ENTRIES];
  logic signed [KEY_W-1:0] key_nxt [MAX_ENTRIES];
  logic signed [VAL_W-1:0] val_nxt [MAX_ENTRIES];
  logic [RW-1:0]           rank_r  [MAX_ENTRIES];
  logic [RW-1:0]           rank_nxt[MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]  valid_r, valid_nxt;

  logic [MAX_ENTRIES-1:0]  match, hit_oh, kept, free_slots, ins_oh;
  logic [RW:0]             aged    [MAX_ENTRIES];
  logic [RW-1:0]           hit_rank;
  logic signed [VAL_W-1:0] hit_val;
  logic [CMPW-1:0]         cap_ext, cap;
  logic                    hit, is_store;

  always_comb begin
    cap_ext = CMPW'(capacity);
    if (cap_ext == '0) begin
      cap = CMPW'(1);
    end else if (cap_ext > CMPW'(MAX_ENTRIES)) begin
      cap = CMPW'(MAX_ENTRIES);
    end else begin
      cap = cap_ext;
    end
  end

  assign is_store  = (s1_item.kind == KIND_STORE);
  assign adv       = s1_valid && (is_store || out_free);
  assign res_valid = adv && !is_store;

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i] = valid_r[i] && (key_r[i] == s1_item.key);
    end
  end

  assign hit    = |match;
  assign hit_oh = match & (~match + MAX_ENTRIES'(1));

  always_comb begin
    hit_rank = '0;
    hit_val  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (hit_oh[i]) begin
        hit_rank = hit_rank | rank_r[i];
        hit_val  = hit_val | val_r[i];
      end
    end
  end

  // touch on hit, age all on a store of a new key, drop past capacity on store
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      aged[i] = {1'b0, rank_r[i]};
      if (hit) begin
        if (hit_oh[i]) begin
          aged[i] = '0;
        end else if (rank_r[i] < hit_rank) begin
          aged[i] = {1'b0, rank_r[i]} + (RW+1)'(1);
        end
      end else if (is_store) begin
        aged[i] = {1'b0, rank_r[i]} + (RW+1)'(1);
      end
      kept[i] = valid_r[i] && !(is_store && (CMPW'(aged[i]) >= cap));
    end
  end

  assign free_slots = ~kept;
  assign ins_oh     = (is_store && !hit) ? (free_slots & (~free_slots + MAX_ENTRIES'(1)))
                                         : '0;

  always_comb begin
    valid_nxt = valid_r;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      key_nxt[i]  = key_r[i];
      val_nxt[i]  = val_r[i];
      rank_nxt[i] = rank_r[i];
      if (adv) begin
        valid_nxt[i] = kept[i] || ins_oh[i];
        if (ins_oh[i] || !kept[i]) begin
          rank_nxt[i] = '0;
        end else begin
          rank_nxt[i] = aged[i][RW-1:0];
        end
        if (ins_oh[i]) begin
          key_nxt[i] = s1_item.key;
          val_nxt[i] = s1_item.value;
        end else if (is_store && hit_oh[i]) begin
          val_nxt[i] = s1_item.value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      key_r[i] <= key_nxt[i];
      val_r[i] <= val_nxt[i];
    end
  end

  assign res.found = hit;
  assign res.value = hit ? hit_val : '0;
endmodule

// ===== hdl/lkv_out_reg.sv =====
// result register driving the result channel
module lkv_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  lkv_pkg::result_t res,
  output logic             out_free,
  lkv_out_if.source        out_chan
);
  import lkv_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r, res_nxt;

  assign out_free = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (res_valid) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_chan.valid      = valid_r;
  assign out_chan.found      = res_r.found;
  assign out_chan.read_value = res_r.value;
endmodule
